/* hw/rtl/pgpg_pkg.sv */
// pgpg_pkg: shared types and constants of the polar gaussian pair generator
// no dependencies; imported by every module of the block

package pgpg_pkg;

  // uniform mapping
  localparam int RAW_W = 64;
  localparam int MAG_W = 54;
  localparam logic [63:0] RAW_LIMIT = 64'd1023 * (64'd1 << 54) + 64'd1022;
  localparam logic [54:0] MOD_SPAN  = (55'd1 << 54) + 55'd1;
  localparam logic [54:0] HALF_SPAN = 55'd1 << 53;

  // log and scaling
  localparam int LOG_FRAC = 56;
  localparam logic [63:0] TWO_LN2_Q62 = 64'h58B9_0BFB_E8E7_BCD6;

  // result format
  localparam int OUT_W = 37;
  localparam logic [63:0] POS_MAX = (64'd1 << (OUT_W - 1)) - 64'd1;
  localparam logic [63:0] NEG_MAX = 64'd1 << (OUT_W - 1);

  // register stages of each part
  localparam int FRONT_LAT  = 9;
  localparam int LOG_LAT    = 2 * LOG_FRAC + 3;
  localparam int ROOT_LAT   = 128;
  localparam int FINISH_LAT = 4;

  // per-pair data that rides along the whole pipe
  typedef struct packed {
    logic             neg_u;
    logic             neg_v;
    logic [MAG_W-1:0] mag_u;
    logic [MAG_W-1:0] mag_v;
    logic [5:0]       half_t;
  } side_t;

  typedef struct packed {
    logic        valid;
    side_t       side;
    logic [61:0] m;
    logic [62:0] x;
    logic [6:0]  tk;
  } front_t;

  typedef struct packed {
    logic        valid;
    side_t       side;
    logic [61:0] m;
    logic [63:0] e;
  } log_t;

  typedef struct packed {
    logic        valid;
    side_t       side;
    logic [63:0] r;
  } root_t;

endpackage

/* hw/rtl/pgpg_front.sv */
// pgpg_front: raw word reduction, squared radius, rejection and normalization
// depends on pgpg_pkg

module pgpg_front import pgpg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [63:0] raw_u,
  input  logic [63:0] raw_v,
  output front_t      fo
);

  // w mod (2^54+1), using 2^54 = -1
  function automatic logic [54:0] mod_reduce(input logic [63:0] w);
    logic [54:0] d;
    d = {1'b0, w[53:0]} - {45'b0, w[63:54]};
    if (w[53:0] < {44'b0, w[63:54]}) d = d + MOD_SPAN;
    return d;
  endfunction

  // stage 1: range check and reduction
  logic        v1;
  logic [54:0] rm_u, rm_v;
  always_ff @(posedge clk) begin
    rm_u <= mod_reduce(raw_u);
    rm_v <= mod_reduce(raw_v);
    if (rst) v1 <= 1'b0;
    else v1 <= in_valid && (raw_u <= RAW_LIMIT) && (raw_v <= RAW_LIMIT);
  end

  // stage 2: sign and magnitude around the center
  logic             v2, n2u, n2v;
  logic [MAG_W-1:0] m2u, m2v;
  logic [54:0]      du, dv;
  assign du = (rm_u < HALF_SPAN) ? HALF_SPAN - rm_u : rm_u - HALF_SPAN;
  assign dv = (rm_v < HALF_SPAN) ? HALF_SPAN - rm_v : rm_v - HALF_SPAN;
  always_ff @(posedge clk) begin
    n2u <= rm_u < HALF_SPAN;
    n2v <= rm_v < HALF_SPAN;
    m2u <= du[MAG_W-1:0];
    m2v <= dv[MAG_W-1:0];
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
  end

  // stage 3: partial products of both squares
  logic             v3, n3u, n3v;
  logic [MAG_W-1:0] m3u, m3v;
  logic [53:0]      uhh, uhl, ull, vhh, vhl, vll;
  always_ff @(posedge clk) begin
    uhh <= m2u[53:27] * m2u[53:27];
    uhl <= m2u[53:27] * m2u[26:0];
    ull <= m2u[26:0] * m2u[26:0];
    vhh <= m2v[53:27] * m2v[53:27];
    vhl <= m2v[53:27] * m2v[26:0];
    vll <= m2v[26:0] * m2v[26:0];
    n3u <= n2u;
    n3v <= n2v;
    m3u <= m2u;
    m3v <= m2v;
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
  end

  // stage 4: each square
  logic             v4, n4u, n4v;
  logic [MAG_W-1:0] m4u, m4v;
  logic [107:0]     su, sv;
  always_ff @(posedge clk) begin
    su  <= {uhh, 54'b0} + {26'b0, uhl, 28'b0} + {54'b0, ull};
    sv  <= {vhh, 54'b0} + {26'b0, vhl, 28'b0} + {54'b0, vll};
    n4u <= n3u;
    n4v <= n3v;
    m4u <= m3u;
    m4v <= m3v;
    if (rst) v4 <= 1'b0;
    else v4 <= v3;
  end

  // stage 5: radius sum, drop zero pair and points outside the disc
  logic             v5, n5u, n5v;
  logic [MAG_W-1:0] m5u, m5v;
  logic [125:0]     x5;
  logic [107:0]     s4;
  assign s4 = su + sv;
  always_ff @(posedge clk) begin
    x5  <= {20'b0, s4[105:0]};
    n5u <= n4u;
    n5v <= n4v;
    m5u <= m4u;
    m5v <= m4v;
    if (rst) v5 <= 1'b0;
    else v5 <= v4 && (s4 != 108'd0) && (s4[107:106] == 2'b00);
  end

  // stages 6 to 8: even left shift until the top bit sits at 124 or 125
  logic             v6, v7, v8, n6u, n6v, n7u, n7v, n8u, n8v;
  logic [MAG_W-1:0] m6u, m6v, m7u, m7v, m8u, m8v;
  logic [125:0]     x6, x7, x8, xa5, xb5, xa6, xb6, xa7, xb7;
  logic [6:0]       h6, h7, h8, ha5, hb5, ha6, hb6, ha7, hb7;

  always_comb begin
    xa5 = (x5[125:62] == 64'd0) ? x5 << 64 : x5;
    ha5 = (x5[125:62] == 64'd0) ? 7'd64 : 7'd0;
    xb5 = (xa5[125:94] == 32'd0) ? xa5 << 32 : xa5;
    hb5 = (xa5[125:94] == 32'd0) ? ha5 + 7'd32 : ha5;
    xa6 = (x6[125:110] == 16'd0) ? x6 << 16 : x6;
    ha6 = (x6[125:110] == 16'd0) ? h6 + 7'd16 : h6;
    xb6 = (xa6[125:118] == 8'd0) ? xa6 << 8 : xa6;
    hb6 = (xa6[125:118] == 8'd0) ? ha6 + 7'd8 : ha6;
    xa7 = (x7[125:122] == 4'd0) ? x7 << 4 : x7;
    ha7 = (x7[125:122] == 4'd0) ? h7 + 7'd4 : h7;
    xb7 = (xa7[125:124] == 2'd0) ? xa7 << 2 : xa7;
    hb7 = (xa7[125:124] == 2'd0) ? ha7 + 7'd2 : ha7;
  end

  always_ff @(posedge clk) begin
    x6 <= xb5;
    h6 <= hb5;
    x7 <= xb6;
    h7 <= hb6;
    x8 <= xb7;
    h8 <= hb7;
    n6u <= n5u;
    n6v <= n5v;
    m6u <= m5u;
    m6v <= m5v;
    n7u <= n6u;
    n7v <= n6v;
    m7u <= m6u;
    m7v <= m6v;
    n8u <= n7u;
    n8v <= n7v;
    m8u <= m7u;
    m8v <= m7v;
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else begin
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
    end
  end

  // stage 9: mantissa, scale exponent and start value of the log
  logic [61:0] m8;
  logic [6:0]  t8;
  logic        hi8;
  assign m8  = x8[125:64];
  assign t8  = h8 - 7'd20;
  assign hi8 = m8[61];

  always_ff @(posedge clk) begin
    fo.side.neg_u  <= n8u;
    fo.side.neg_v  <= n8v;
    fo.side.mag_u  <= m8u;
    fo.side.mag_v  <= m8v;
    fo.side.half_t <= t8[6:1];
    fo.m  <= m8;
    fo.x  <= hi8 ? {m8, 1'b0} : {m8[60:0], 2'b00};
    fo.tk <= t8 + (hi8 ? 7'd1 : 7'd2);
    if (rst) fo.valid <= 1'b0;
    else fo.valid <= v8;
  end

endmodule

/* hw/rtl/pgpg_log.sv */
// pgpg_log: log2 by repeated squaring, then scaling to -2 ln s
// depends on pgpg_pkg

module pgpg_log import pgpg_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  front_t fi,
  output log_t   lo
);

  typedef struct packed {
    side_t       side;
    logic [61:0] m;
    logic [6:0]  tk;
  } carry_t;

  logic                v_x [0:LOG_FRAC];
  logic [62:0]         x_q [0:LOG_FRAC];
  logic [LOG_FRAC-1:0] f_q [0:LOG_FRAC];
  carry_t              c_q [0:LOG_FRAC];

  logic                va  [0:LOG_FRAC-1];
  logic [61:0]         hh  [0:LOG_FRAC-1];
  logic [62:0]         hl  [0:LOG_FRAC-1];
  logic [63:0]         ll  [0:LOG_FRAC-1];
  logic [LOG_FRAC-1:0] fa  [0:LOG_FRAC-1];
  carry_t              ca  [0:LOG_FRAC-1];

  assign v_x[0] = fi.valid;
  assign x_q[0] = fi.x;
  assign f_q[0] = '0;
  assign c_q[0] = '{side: fi.side, m: fi.m, tk: fi.tk};

  // one fraction bit per squaring, two stages each
  for (genvar i = 0; i < LOG_FRAC; i++) begin : g_sq
    logic [125:0] sq;
    logic [63:0]  y;

    // partial products
    always_ff @(posedge clk) begin
      hh[i] <= x_q[i][62:32] * x_q[i][62:32];
      hl[i] <= x_q[i][62:32] * x_q[i][31:0];
      ll[i] <= x_q[i][31:0] * x_q[i][31:0];
      fa[i] <= f_q[i];
      ca[i] <= c_q[i];
      if (rst) va[i] <= 1'b0;
      else va[i] <= v_x[i];
    end

    // square back to Q62, halve when it reaches two
    assign sq = {hh[i], 64'b0} + {30'b0, hl[i], 33'b0} + {62'b0, ll[i]};
    assign y  = sq[125:62];

    always_ff @(posedge clk) begin
      x_q[i+1] <= y[63] ? y[63:1] : y[62:0];
      f_q[i+1] <= {fa[i][LOG_FRAC-2:0], y[63]};
      c_q[i+1] <= ca[i];
      if (rst) v_x[i+1] <= 1'b0;
      else v_x[i+1] <= va[i];
    end
  end

  // -log2 s in Q56
  logic        vn;
  logic [63:0] n;
  carry_t      cn;
  always_ff @(posedge clk) begin
    n  <= {1'b0, c_q[LOG_FRAC].tk, 56'b0} - {8'b0, f_q[LOG_FRAC]};
    cn <= c_q[LOG_FRAC];
    if (rst) vn <= 1'b0;
    else vn <= v_x[LOG_FRAC];
  end

  // times 2 ln 2: partial products
  logic        vp;
  logic [63:0] p11, p10, p01, p00;
  carry_t      cp;
  always_ff @(posedge clk) begin
    p11 <= n[63:32] * TWO_LN2_Q62[63:32];
    p10 <= n[63:32] * TWO_LN2_Q62[31:0];
    p01 <= n[31:0] * TWO_LN2_Q62[63:32];
    p00 <= n[31:0] * TWO_LN2_Q62[31:0];
    cp  <= cn;
    if (rst) vp <= 1'b0;
    else vp <= vn;
  end

  // sum and drop to Q56
  logic [127:0] prod;
  assign prod = {p11, 64'b0} + {32'b0, p10, 32'b0} + {32'b0, p01, 32'b0} + {64'b0, p00};

  always_ff @(posedge clk) begin
    lo.side <= cp.side;
    lo.m    <= cp.m;
    lo.e    <= prod[125:62];
    if (rst) lo.valid <= 1'b0;
    else lo.valid <= vp;
  end

endmodule

/* hw/rtl/pgpg_root.sv */
// pgpg_root: restoring divide by the mantissa, then restoring square root
// depends on pgpg_pkg

module pgpg_root import pgpg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  log_t  li,
  output root_t ro
);

  localparam int STEPS = 64;

  // divider pipe
  logic        dv [0:STEPS];
  logic [63:0] dh [0:STEPS];
  logic [7:0]  dl [0:STEPS];
  logic [63:0] dq [0:STEPS];
  logic [61:0] dm [0:STEPS];
  side_t       ds [0:STEPS];

  // square root pipe
  logic        sv [0:STEPS];
  logic [64:0] sr [0:STEPS];
  logic [63:0] st [0:STEPS];
  logic [63:0] sb [0:STEPS];
  side_t       ss [0:STEPS];

  // dividend is e * 2^56
  assign dv[0] = li.valid;
  assign dh[0] = {8'b0, li.e[63:8]};
  assign dl[0] = li.e[7:0];
  assign dq[0] = '0;
  assign dm[0] = li.m;
  assign ds[0] = li.side;

  // one quotient bit per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_div
    logic [64:0] h2, diff;
    logic        take;
    assign h2   = {dh[i], dl[i][7]};
    assign take = h2[64] || (h2[63:0] >= {2'b0, dm[i]});
    assign diff = h2 - {3'b0, dm[i]};
    always_ff @(posedge clk) begin
      dh[i+1] <= take ? diff[63:0] : h2[63:0];
      dl[i+1] <= {dl[i][6:0], 1'b0};
      dq[i+1] <= {dq[i][62:0], take};
      dm[i+1] <= dm[i];
      ds[i+1] <= ds[i];
      if (rst) dv[i+1] <= 1'b0;
      else dv[i+1] <= dv[i];
    end
  end

  // radicand is q * 2^64
  assign sv[0] = dv[STEPS];
  assign sr[0] = '0;
  assign st[0] = '0;
  assign sb[0] = dq[STEPS];
  assign ss[0] = ds[STEPS];

  // one root bit per stage
  for (genvar j = 0; j < STEPS; j++) begin : g_sqrt
    logic [66:0] rs, trial, rd;
    logic        ge;
    assign rs    = {sr[j], sb[j][63:62]};
    assign trial = {1'b0, st[j], 2'b01};
    assign ge    = rs >= trial;
    assign rd    = rs - trial;
    always_ff @(posedge clk) begin
      sr[j+1] <= ge ? rd[64:0] : rs[64:0];
      st[j+1] <= {st[j][62:0], ge};
      sb[j+1] <= {sb[j][61:0], 2'b00};
      ss[j+1] <= ss[j];
      if (rst) sv[j+1] <= 1'b0;
      else sv[j+1] <= sv[j];
    end
  end

  assign ro = '{valid: sv[STEPS], side: ss[STEPS], r: st[STEPS]};

endmodule

/* hw/rtl/pgpg_finish.sv */
// pgpg_finish: scales both magnitudes by the root, rounds, saturates, signs
// depends on pgpg_pkg

module pgpg_finish import pgpg_pkg::*; #(
  parameter int OUT_FRAC_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  root_t                   ri,
  output logic                    done,
  output logic signed [OUT_W-1:0] gauss_a,
  output logic signed [OUT_W-1:0] gauss_b
);

  localparam int SH = 110 - OUT_FRAC_BITS;
  localparam logic [127:0] RND = 128'd1 << (SH - 1);

  // clamp to the output range and apply the sign
  function automatic logic [OUT_W-1:0] clamp(input logic neg, input logic [63:0] z);
    logic [63:0] c;
    if (neg) begin
      c = (z > NEG_MAX) ? NEG_MAX : z;
      c = 64'd0 - c;
    end else begin
      c = (z > POS_MAX) ? POS_MAX : z;
    end
    return c[OUT_W-1:0];
  endfunction

  // stage 1: magnitudes scaled by 2^(t/2)
  logic        v1, n1u, n1v;
  logic [63:0] a1u, a1v, r1;
  always_ff @(posedge clk) begin
    a1u <= {10'b0, ri.side.mag_u} << ri.side.half_t;
    a1v <= {10'b0, ri.side.mag_v} << ri.side.half_t;
    r1  <= ri.r;
    n1u <= ri.side.neg_u;
    n1v <= ri.side.neg_v;
    if (rst) v1 <= 1'b0;
    else v1 <= ri.valid;
  end

  // stage 2: partial products
  logic        v2, n2u, n2v;
  logic [63:0] u11, u10, u01, u00, w11, w10, w01, w00;
  always_ff @(posedge clk) begin
    u11 <= a1u[63:32] * r1[63:32];
    u10 <= a1u[63:32] * r1[31:0];
    u01 <= a1u[31:0] * r1[63:32];
    u00 <= a1u[31:0] * r1[31:0];
    w11 <= a1v[63:32] * r1[63:32];
    w10 <= a1v[63:32] * r1[31:0];
    w01 <= a1v[31:0] * r1[63:32];
    w00 <= a1v[31:0] * r1[31:0];
    n2u <= n1u;
    n2v <= n1v;
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
  end

  // stage 3: full product plus rounding half
  logic         v3, n3u, n3v;
  logic [127:0] s3u, s3v;
  always_ff @(posedge clk) begin
    s3u <= {u11, 64'b0} + {32'b0, u10, 32'b0} + {32'b0, u01, 32'b0} + {64'b0, u00} + RND;
    s3v <= {w11, 64'b0} + {32'b0, w10, 32'b0} + {32'b0, w01, 32'b0} + {64'b0, w00} + RND;
    n3u <= n2u;
    n3v <= n2v;
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
  end

  // stage 4: shift to output scale, saturate
  logic [127:0] z3u, z3v;
  assign z3u = s3u >> SH;
  assign z3v = s3v >> SH;

  always_ff @(posedge clk) begin
    gauss_a <= clamp(n3u, z3u[63:0]);
    gauss_b <= clamp(n3v, z3v[63:0]);
    if (rst) done <= 1'b0;
    else done <= v3;
  end

endmodule

/* hw/rtl/polar_gaussian_pair_generator_core.sv */
// polar_gaussian_pair_generator_core: top level of the polar gaussian generator
// depends on pgpg_pkg, pgpg_front, pgpg_log, pgpg_root, pgpg_finish
//
// Usage:
//   Drive raw_u and raw_v with two fresh 64-bit uniform random words and pulse
//   start; the word pair is taken at any clock edge with start high and busy
//   low. busy is high only while rst is asserted, so one pair can be taken in
//   every cycle: throughput is one word pair per clock.
//   A pair whose words fall in the biased tail, whose point is the origin, or
//   whose point lies on or outside the unit circle is dropped and gives no
//   result; the source just keeps feeding new words.
//   A kept pair leaves the end of the pipe as a result: done is high for one
//   cycle with gauss_a and gauss_b, two independent standard normal values in
//   signed fixed point with OUT_FRAC_BITS fraction bits, saturated to 37 bits.
//   The latency is set by the log2 chain (two stages per fraction bit, 56
//   bits) and by the divider and square root, one result bit per stage each.
//   The receiver cannot hold results off; results come out in input order.
//   Synchronous reset empties the pipe: pairs in flight are discarded.

module polar_gaussian_pair_generator_core import pgpg_pkg::*; #(
  parameter int OUT_FRAC_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [RAW_W-1:0]        raw_u,
  input  logic [RAW_W-1:0]        raw_v,
  output logic                    done,
  output logic signed [OUT_W-1:0] gauss_a,
  output logic signed [OUT_W-1:0] gauss_b
);

  localparam int PIPE_DEPTH = FRONT_LAT + LOG_LAT + ROOT_LAT + FINISH_LAT;

  front_t fo;
  log_t   lo;
  root_t  ro;

  // the pipe never stalls
  assign busy = rst;

  pgpg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .raw_u    (raw_u),
    .raw_v    (raw_v),
    .fo       (fo)
  );

  pgpg_log u_log (
    .clk (clk),
    .rst (rst),
    .fi  (fo),
    .lo  (lo)
  );

  pgpg_root u_root (
    .clk (clk),
    .rst (rst),
    .li  (lo),
    .ro  (ro)
  );

  pgpg_finish #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_finish (
    .clk     (clk),
    .rst     (rst),
    .ri      (ro),
    .done    (done),
    .gauss_a (gauss_a),
    .gauss_b (gauss_b)
  );

  // no word comes out right after reset
  a_no_done_after_reset: assert property (@(posedge clk) !rst && $past(rst) |-> !done)
    else $error("done raised right after reset");

  // every word out traces back to a pair taken one pipe depth earlier
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_DEPTH))
    else $error("done without a pair taken one pipe depth earlier");

  // a stage valid in the middle of the pipe implies the front accepted work
  a_root_has_source: assert property (@(posedge clk) disable iff (rst)
    ro.valid |-> $past(start && !busy, FRONT_LAT + LOG_LAT + ROOT_LAT))
    else $error("root stage valid without a matching pair");

endmodule

/* dv/testbench.sv */
// testbench: self-checking bench for polar_gaussian_pair_generator_core
// depends on pgpg_pkg and the core; bit-exact fixed-point predictor inside
`timescale 1ns / 100ps

module testbench;
  import pgpg_pkg::*;

  localparam int FRAC_BITS = 32;
  localparam int PIPE_LAT  = 256;
  localparam int STALL_MAX = 4000;
  localparam int RAND_WORDS = 1250;
  localparam logic [63:0] SPAN64 = 64'h0040_0000_0000_0001;
  localparam logic [63:0] MID64  = 64'h0020_0000_0000_0000;

  typedef struct {
    logic [OUT_W-1:0] a;
    logic [OUT_W-1:0] b;
  } gauss_pair_t;

  // expected gaussian pairs and the fixed-point polar transform
  class gauss_scoreboard;
    gauss_pair_t pending[$];
    int errors = 0;

    task report(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    function bit to_signmag(logic [63:0] w, output bit neg, output logic [63:0] mag);
      logic [63:0] m;
      if (w > RAW_LIMIT) return 0;
      m = w % SPAN64;
      if (m >= MID64) begin
        neg = 0;
        mag = m - MID64;
      end else begin
        neg = 1;
        mag = MID64 - m;
      end
      return 1;
    endfunction

    function logic [OUT_W-1:0] scale_out(bit neg, logic [63:0] mag, int half_t,
                                         logic [63:0] r);
      logic [63:0] ms, z;
      logic [127:0] prod;
      int sh;
      sh = 110 - FRAC_BITS;
      ms = mag << half_t;
      prod = {64'd0, ms} * {64'd0, r};
      prod = prod + (128'd1 << (sh - 1));
      z = 64'(prod >> sh);
      if (neg) begin
        if (z > NEG_MAX) z = NEG_MAX;
        z = 64'd0 - z;
        return z[OUT_W-1:0];
      end
      if (z > POS_MAX) z = POS_MAX;
      return z[OUT_W-1:0];
    endfunction

    // returns 0 when the word pair is dropped
    function bit polar_pair(logic [63:0] wu, logic [63:0] wv, output gauss_pair_t res);
      bit nu, nv;
      logic [63:0] mu, mv, m, x, frac, n, e, q, r, c;
      logic [127:0] s, tmp, sq;
      int p, sh2, t, k;
      if (!to_signmag(wu, nu, mu)) return 0;
      if (!to_signmag(wv, nv, mv)) return 0;
      s = {64'd0, mu} * {64'd0, mu} + {64'd0, mv} * {64'd0, mv};
      if (s == 0 || s >= (128'd1 << 106)) return 0;
      p = 0;
      for (int i = 0; i < 128; i++) if (s[i]) p = i;
      sh2 = (124 - p) + (p & 1);
      tmp = s << sh2;
      m = tmp[127:64];
      t = sh2 - 20;
      // log2 of the normalized mantissa by repeated squaring
      if (m >= (64'd1 << 61)) begin
        x = m << 1;
        k = 1;
      end else begin
        x = m << 2;
        k = 2;
      end
      frac = 0;
      for (int i = 0; i < LOG_FRAC; i++) begin
        sq = {64'd0, x} * {64'd0, x};
        x = 64'(sq >> 62);
        frac = frac << 1;
        if (x[63]) begin
          x = x >> 1;
          frac[0] = 1'b1;
        end
      end
      n = (64'(t + k) << LOG_FRAC) - frac;
      sq = {64'd0, n} * {64'd0, TWO_LN2_Q62};
      e = 64'(sq >> 62);
      q = 64'(({64'd0, e} << 56) / {64'd0, m});
      // integer square root of q * 2^64
      r = 0;
      for (int b = 63; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if ({64'd0, c} * {64'd0, c} <= {q, 64'd0}) r = c;
      end
      res.a = scale_out(nu, mu, t >> 1, r);
      res.b = scale_out(nv, mv, t >> 1, r);
      return 1;
    endfunction

    function void note_word(logic [63:0] wu, logic [63:0] wv);
      gauss_pair_t res;
      if (polar_pair(wu, wv, res)) pending.push_back(res);
    endfunction

    task check_word(logic [OUT_W-1:0] a, logic [OUT_W-1:0] b);
      gauss_pair_t want;
      if (pending.size() == 0) begin
        report("unexpected word", a, '0);
        return;
      end
      want = pending.pop_front();
      if (a !== want.a) report("gauss_a", a, want.a);
      if (b !== want.b) report("gauss_b", b, want.b);
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [RAW_W-1:0] raw_u = '0;
  logic [RAW_W-1:0] raw_v = '0;
  logic done;
  logic signed [OUT_W-1:0] gauss_a, gauss_b;

  gauss_scoreboard sb = new();
  int idle_cycles = 0;

  polar_gaussian_pair_generator_core #(.OUT_FRAC_BITS(FRAC_BITS)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .raw_u(raw_u), .raw_v(raw_v),
    .done(done), .gauss_a(gauss_a), .gauss_b(gauss_b)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // accepted inputs, results and the stall watchdog
  always @(posedge clk) begin
    if (!rst) begin
      idle_cycles++;
      if (start && !busy) begin
        sb.note_word(raw_u, raw_v);
        idle_cycles = 0;
      end
      if (done === 1'b1) begin
        sb.check_word(gauss_a, gauss_b);
        idle_cycles = 0;
      end
      if (idle_cycles >= STALL_MAX) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task send_word(logic [63:0] wu, logic [63:0] wv);
    int gap, roll;
    roll = $urandom_range(99);
    if (roll < 70) gap = 0;
    else if (roll < 95) gap = $urandom_range(3, 1);
    else gap = $urandom_range(60, 10);
    if (gap > 0) begin
      start = 0;
      repeat (gap) @(negedge clk);
    end
    start = 1;
    raw_u = wu;
    raw_v = wv;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // a word that maps to center + off (off may be negative)
  function logic [63:0] from_offset(longint off);
    logic [63:0] w;
    w = MID64 + 64'(off);
    return w + SPAN64 * $urandom_range(1022);
  endfunction

  function logic [63:0] rand_raw();
    int roll;
    longint off;
    roll = $urandom_range(99);
    off = longint'({$urandom, $urandom} >> $urandom_range(63, 11));
    if ($urandom_range(1)) off = -off;
    if (roll < 70) return {$urandom, $urandom};
    if (roll < 88) return from_offset(off);
    if (roll < 95) return from_offset($urandom_range(1) ? longint'(MID64) - off
                                                         : off - longint'(MID64));
    return RAW_LIMIT + 64'($urandom_range(1000, 1));
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: range edges, dropped pairs, tiny and near-unit radius
    send_word(64'd0, 64'd0);
    send_word(RAW_LIMIT, MID64);
    send_word(RAW_LIMIT + 64'd1, MID64);
    send_word(MID64, '1);
    send_word('1, '1);
    send_word(MID64, MID64);
    send_word(MID64 + SPAN64 * 64'd1022, MID64 + SPAN64 * 64'd7);
    send_word(MID64 + 64'd1, MID64);
    send_word(MID64, MID64 - 64'd1);
    send_word(MID64 - 64'd1, MID64 + 64'd1);
    send_word(64'd1 << 54, MID64);
    send_word(64'd1, MID64);
    send_word(64'd2, MID64);
    send_word(MID64, 64'd3);
    send_word(from_offset(64'h0016_A09E_667F_3BCC), from_offset(-64'sh0016_A09E_667F_3BCC));
    send_word(from_offset(64'h0016_A09E_667F_3BCD), from_offset(64'h0016_A09E_667F_3BCD));
    send_word(from_offset(1 << 26), from_offset(-(1 << 26)));
    send_word(from_offset(-64'sh001F_FFFF_FFFF_FFFF), from_offset(5));
    send_word(from_offset(64'h0010_0000_0000_0000), from_offset(64'h0008_0000_0000_0000));
    send_word('1 >> 1, 64'h5555_5555_5555_5555);

    for (int i = 0; i < RAND_WORDS; i++) begin
      if (i == RAND_WORDS / 2) begin
        start = 0;
        while (sb.pending.size() != 0) @(negedge clk);
      end
      // some back-to-back bursts
      send_word(rand_raw(), rand_raw());
    end
    start = 0;

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 20) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
